// ===== rtl/hufd_pkg.sv =====
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types, constants and helpers for the Huffman tree decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int IDX_W         = 9;
  localparam int SYM_W         = 8;
  localparam int CNT_W         = 4;
  localparam int BITS_PER_BYTE = 8;

  localparam logic [IDX_W-1:0] ROOT_RESET = 9'd511;

  // opcodes of an input word
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // one tree node as held in the node memory
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  // a node with no children is a leaf
  function automatic logic node_is_leaf(input node_t n);
    node_is_leaf = (n.left == '0) && (n.right == '0);
  endfunction

  // node index falls inside the implemented slots
  function automatic logic node_in_range(input logic [IDX_W-1:0] idx, input int slots);
    node_in_range = (32'(idx) < 32'(slots));
  endfunction

endpackage

// ===== rtl/hufd_in_if.sv =====
// ----------------------------------------------------------------------------
// hufd_in_if
// Input channel: node load words and data byte words.
// ----------------------------------------------------------------------------
interface hufd_in_if import hufd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [IDX_W-1:0] node_index;
  logic [IDX_W-1:0] left_index;
  logic [IDX_W-1:0] right_index;
  logic [SYM_W-1:0] node_symbol;
  logic [7:0]       data_byte;
  logic [CNT_W-1:0] bit_count;
  logic             end_of_stream;

  modport source (
    output valid, opcode, node_index, left_index, right_index, node_symbol,
           data_byte, bit_count, end_of_stream,
    input  ready
  );

  modport sink (
    input  valid, opcode, node_index, left_index, right_index, node_symbol,
           data_byte, bit_count, end_of_stream,
    output ready
  );

endinterface

// ===== rtl/hufd_out_if.sv =====
// ----------------------------------------------------------------------------
// hufd_out_if
// Result channel: one decoded symbol per word.
// ----------------------------------------------------------------------------
interface hufd_out_if import hufd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (
    output valid, symbol, last,
    input  ready
  );

  modport sink (
    input  valid, symbol, last,
    output ready
  );

endinterface

// ===== rtl/hufd_node_mem.sv =====
// ----------------------------------------------------------------------------
// hufd_node_mem
// Single-port-write, single-port-read node memory with registered read data.
// Writes beyond the implemented slots are dropped; reads there return zeros.
// ----------------------------------------------------------------------------
module hufd_node_mem import hufd_pkg::*; #(
  parameter int NODE_SLOTS = 512
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  node_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output node_t            rd_data
);

  localparam int ADDR_W = $clog2(NODE_SLOTS);

  node_t mem [NODE_SLOTS];

  logic [ADDR_W+IDX_W-1:0] wr_ext;
  logic [ADDR_W+IDX_W-1:0] rd_ext;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr;
  node_t                   rd_q_r;
  logic                    rd_oob_r;

  // index to address, widened or narrowed to the memory depth
  assign wr_ext  = {{ADDR_W{1'b0}}, wr_idx};
  assign rd_ext  = {{ADDR_W{1'b0}}, rd_idx};
  assign wr_addr = wr_ext[ADDR_W-1:0];
  assign rd_addr = rd_ext[ADDR_W-1:0];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en && node_in_range(wr_idx, NODE_SLOTS)) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_oob_r <= !node_in_range(rd_idx, NODE_SLOTS);
    end
  end

  assign rd_data = rd_oob_r ? node_t'('0) : rd_q_r;

endmodule

// ===== rtl/huffman_tree_decoder_top.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// Huffman decoder walking a code tree held in a node memory.
//
//   channel  direction  handshake        contents
//   in_ch    sink       valid / ready    node load or data byte word
//   out_ch   source     valid / ready    decoded symbol, last flag
//   cfg_*    input      write enable     root node index
//
// A load word is written to the node memory when it is accepted. A data
// word is walked one tree step per valid bit, each step into a child
// waiting on the registered node memory read; a leaf reached while the
// root is itself a leaf holds the next bit back. Output stalls hold the
// walk. After reset and after each root write the root node is fetched
// (ST_REFRESH) before the next word is taken. Reset is synchronous, active
// low.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_top import hufd_pkg::*; #(
  parameter int NODE_SLOTS = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  hufd_in_if.sink          in_ch,
  hufd_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFRESH,
    ST_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  node_t            node_r, node_nxt;
  node_t            root_node_r, root_node_nxt;
  logic             stale_r, stale_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             eos_r, eos_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [SYM_W-1:0] hold_sym_r, hold_sym_nxt;
  logic             out_v_r, out_v_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_rdy;
  logic             mem_wr_en;
  node_t            mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_idx;
  node_t            mem_rd_data;

  logic             out_free;
  logic             e1;
  logic             e2;
  logic             bit_go;
  logic             emit;
  logic [SYM_W-1:0] emit_sym;
  logic             finish;
  logic             stall;
  node_t            eff_node;
  logic [IDX_W-1:0] eff_walk;
  logic [IDX_W-1:0] child;
  logic             load_ok;

  hufd_node_mem #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_idx  (in_ch.node_index),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_idx  (mem_rd_idx),
    .rd_data (mem_rd_data)
  );

  assign in_rdy      = (state_r == ST_IDLE) && !stale_r;
  assign in_ch.ready = in_rdy;

  assign mem_wr_data = '{left: in_ch.left_index, right: in_ch.right_index,
                         sym: in_ch.node_symbol};
  assign mem_wr_en   = in_ch.valid && in_rdy && (in_ch.opcode == OP_LOAD);
  assign load_ok     = mem_wr_en && node_in_range(in_ch.node_index, NODE_SLOTS);

  assign out_free = !out_v_r || out_ch.ready;

  // resolve the pending child fetch from the node memory
  always_comb begin
    e1       = 1'b0;
    eff_node = node_r;
    eff_walk = walk_r;
    if (pend_r) begin
      if (node_is_leaf(mem_rd_data)) begin
        e1       = 1'b1;
        eff_node = root_node_r;
        eff_walk = root_r;
      end else begin
        eff_node = mem_rd_data;
        eff_walk = pend_idx_r;
      end
    end
  end

  // one bit step on the resolved node
  assign bit_go   = (rem_r != '0) && !(e1 && node_is_leaf(eff_node));
  assign e2       = bit_go && node_is_leaf(eff_node);
  assign emit     = e1 || e2;
  assign emit_sym = e1 ? mem_rd_data.sym : eff_node.sym;
  assign child    = data_r[7] ? eff_node.right : eff_node.left;
  assign finish   = !pend_r && (rem_r == '0);
  assign stall    = hold_v_r && !out_free && (emit || finish);

  // next state
  always_comb begin
    state_nxt     = state_r;
    root_nxt      = root_r;
    walk_nxt      = walk_r;
    node_nxt      = node_r;
    root_node_nxt = root_node_r;
    stale_nxt     = stale_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    data_nxt      = data_r;
    rem_nxt       = rem_r;
    eos_nxt       = eos_r;
    hold_v_nxt    = hold_v_r;
    hold_sym_nxt  = hold_sym_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    mem_rd_en     = 1'b0;
    mem_rd_idx    = root_r;

    case (state_r)
      ST_IDLE: begin
        if (stale_r) begin
          mem_rd_en = 1'b1;
          state_nxt = ST_REFRESH;
        end else if (in_ch.valid) begin
          if (in_ch.opcode == OP_DECODE) begin
            data_nxt  = in_ch.data_byte;
            rem_nxt   = (in_ch.bit_count > CNT_W'(BITS_PER_BYTE)) ?
                        CNT_W'(BITS_PER_BYTE) : in_ch.bit_count;
            eos_nxt   = in_ch.end_of_stream;
            pend_nxt  = 1'b0;
            state_nxt = ST_RUN;
          end else begin
            // keep the cached root and walk nodes in step with the memory
            if (load_ok && (in_ch.node_index == root_r)) begin
              root_node_nxt = mem_wr_data;
            end
            if (load_ok && (in_ch.node_index == walk_r)) begin
              node_nxt = mem_wr_data;
            end
          end
        end
      end

      ST_REFRESH: begin
        root_node_nxt = mem_rd_data;
        node_nxt      = mem_rd_data;
        walk_nxt      = root_r;
        stale_nxt     = 1'b0;
        state_nxt     = ST_IDLE;
      end

      ST_RUN: begin
        if (!stall) begin
          // symbol goes to the hold slot, the previous one moves out
          if (emit) begin
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_sym_nxt  = hold_sym_r;
              out_last_nxt = 1'b0;
            end
            hold_v_nxt   = 1'b1;
            hold_sym_nxt = emit_sym;
          end

          if (bit_go) begin
            rem_nxt  = rem_r - CNT_W'(1);
            data_nxt = {data_r[6:0], 1'b0};
            if (e2) begin
              walk_nxt = root_r;
              node_nxt = root_node_r;
              pend_nxt = 1'b0;
            end else begin
              mem_rd_en    = 1'b1;
              mem_rd_idx   = child;
              pend_nxt     = 1'b1;
              pend_idx_nxt = child;
            end
          end else begin
            walk_nxt = eff_walk;
            node_nxt = eff_node;
            pend_nxt = 1'b0;
          end

          // end of word: flush the held symbol as the last one
          if (finish) begin
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_sym_nxt  = hold_sym_r;
              out_last_nxt = 1'b1;
              hold_v_nxt   = 1'b0;
            end
            if (eos_r) begin
              walk_nxt = root_r;
              node_nxt = root_node_r;
            end
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // root register write restarts the walk and refetches the root
    if (cfg_wr_en) begin
      root_nxt  = cfg_wr_data;
      walk_nxt  = cfg_wr_data;
      stale_nxt = 1'b1;
      if (state_nxt == ST_REFRESH) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      root_r   <= ROOT_RESET;
      walk_r   <= ROOT_RESET;
      stale_r  <= 1'b1;
      pend_r   <= 1'b0;
      rem_r    <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      root_r   <= root_nxt;
      walk_r   <= walk_nxt;
      stale_r  <= stale_nxt;
      pend_r   <= pend_nxt;
      rem_r    <= rem_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    node_r      <= node_nxt;
    root_node_r <= root_node_nxt;
    pend_idx_r  <= pend_idx_nxt;
    data_r      <= data_nxt;
    eos_r       <= eos_nxt;
    hold_sym_r  <= hold_sym_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.symbol = out_sym_r;
  assign out_ch.last   = out_last_r;

endmodule
